// File: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the open-drain I2C master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_DATA_W-1:0] QUARTER_RESET = 12'd100;
	localparam logic [CFG_DATA_W-1:0] SETUP_RESET   = 12'd400;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUARTER = 2'd0,
		REG_SETUP   = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ACT_TICK  = 3'd0,
		ACT_START = 3'd1,
		ACT_WRITE = 3'd2,
		ACT_READ  = 3'd3,
		ACT_STOP  = 3'd4
	} action_t;

	typedef enum logic [3:0] {
		PH_IDLE        = 4'd0,
		PH_START_REL   = 4'd1,
		PH_START_SETUP = 4'd2,
		PH_START_HOLD  = 4'd3,
		PH_BIT_LA      = 4'd4,
		PH_BIT_LB      = 4'd5,
		PH_BIT_HA      = 4'd6,
		PH_BIT_HB      = 4'd7,
		PH_ACK_LA      = 4'd8,
		PH_ACK_LB      = 4'd9,
		PH_ACK_HA      = 4'd10,
		PH_ACK_HB      = 4'd11,
		PH_STOP_LOW    = 4'd12,
		PH_STOP_SCL    = 4'd13,
		PH_STOP_SDA    = 4'd14
	} phase_t;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic [2:0] action;
		logic [6:0] device_addr;
		logic       read_flag;
		logic [7:0] data_byte;
		logic       send_nack;
		logic       sda_level;
	} cmd_t;

	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic       busy_res;
		logic       rx_valid;
		logic [7:0] rx_byte;
	} res_t;

endpackage

// File: rtl/i2cm_cmd_if.sv
// ----------------------------------------------------------------------------
// i2cm_cmd_if
// Command channel: one timer tick with an optional byte-level command.
// ----------------------------------------------------------------------------
interface i2cm_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [6:0] device_addr;
	logic       read_flag;
	logic [7:0] data_byte;
	logic       send_nack;
	logic       sda_level;

	modport source (
		output valid, action, device_addr, read_flag, data_byte, send_nack, sda_level,
		input  ready
	);
	modport sink (
		input  valid, action, device_addr, read_flag, data_byte, send_nack, sda_level,
		output ready
	);
endinterface

// File: rtl/i2cm_res_if.sv
// ----------------------------------------------------------------------------
// i2cm_res_if
// Result channel: line levels and status after one tick.
// ----------------------------------------------------------------------------
interface i2cm_res_if;
	logic       valid;
	logic       ready;
	logic       scl_release;
	logic       sda_release;
	logic       busy_res;
	logic       rx_valid;
	logic [7:0] rx_byte;

	modport source (
		output valid, scl_release, sda_release, busy_res, rx_valid, rx_byte,
		input  ready
	);
	modport sink (
		input  valid, scl_release, sda_release, busy_res, rx_valid, rx_byte,
		output ready
	);
endinterface

// File: rtl/i2cm_cfg_if.sv
// ----------------------------------------------------------------------------
// i2cm_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface i2cm_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [11:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// File: rtl/i2cm_core.sv
// ----------------------------------------------------------------------------
// i2cm_core
// Bus state machine of the I2C master: phase, tick counter, bit counter and
// shift register, advanced by one tick whenever step is high.
// ----------------------------------------------------------------------------
module i2cm_core
	import i2cm_pkg::*;
#(
	parameter int COUNTER_WIDTH = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  cmd_t                  item,
	input  logic [CFG_DATA_W-1:0] quarter_ticks,
	input  logic [CFG_DATA_W-1:0] start_setup_ticks,
	output res_t                  nxt
);

	localparam int DW = ((COUNTER_WIDTH > CFG_DATA_W) ? COUNTER_WIDTH : CFG_DATA_W) + 1;
	localparam logic [DW-1:0] CAP = DW'(1) << COUNTER_WIDTH;

	phase_t                   phase_q, n_phase, enter_p;
	logic [COUNTER_WIDTH-1:0] tick_q, n_tick;
	logic [3:0]               bit_q, n_bit;
	logic [7:0]               shift_q, n_shift;
	logic [7:0]               rx_hold_q, n_rx_hold;
	logic                     scl_q, n_scl;
	logic                     sda_q, n_sda;
	logic                     nack_q, n_nack;
	logic                     reading_q, n_reading;
	logic                     enter_en;
	logic                     rxv;
	logic [CFG_DATA_W-1:0]    dur_raw;
	logic [DW-1:0]            dur;
	logic [DW-1:0]            cnt_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tick_q    <= '0;
			bit_q     <= '0;
			shift_q   <= '0;
			rx_hold_q <= '0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			nack_q    <= 1'b0;
			reading_q <= 1'b0;
		end else if (step) begin
			phase_q   <= n_phase;
			tick_q    <= n_tick;
			bit_q     <= n_bit;
			shift_q   <= n_shift;
			rx_hold_q <= n_rx_hold;
			scl_q     <= n_scl;
			sda_q     <= n_sda;
			nack_q    <= n_nack;
			reading_q <= n_reading;
		end
	end

	// phase duration, zero counts as one, saturated at the counter range
	always_comb begin
		dur_raw = (phase_q == PH_START_SETUP) ? start_setup_ticks : quarter_ticks;
		dur     = DW'(dur_raw);
		if (dur_raw == '0) begin
			dur = DW'(1);
		end else if (dur > CAP) begin
			dur = CAP;
		end
		cnt_inc = DW'(tick_q) + DW'(1);
	end

	always_comb begin
		n_phase   = phase_q;
		n_tick    = tick_q;
		n_bit     = bit_q;
		n_shift   = shift_q;
		n_rx_hold = rx_hold_q;
		n_scl     = scl_q;
		n_sda     = sda_q;
		n_nack    = nack_q;
		n_reading = reading_q;
		enter_en  = 1'b0;
		enter_p   = PH_IDLE;
		rxv       = 1'b0;

		if (phase_q == PH_IDLE) begin
			unique case (action_t'(item.action))
				ACT_START: begin
					n_shift   = {item.device_addr, item.read_flag};
					n_reading = 1'b0;
					n_bit     = '0;
					enter_en  = 1'b1;
					enter_p   = PH_START_REL;
				end
				ACT_WRITE: begin
					n_shift   = item.data_byte;
					n_reading = 1'b0;
					n_bit     = '0;
					enter_en  = 1'b1;
					enter_p   = PH_BIT_LA;
				end
				ACT_READ: begin
					n_shift   = '0;
					n_reading = 1'b1;
					n_nack    = item.send_nack;
					n_bit     = '0;
					enter_en  = 1'b1;
					enter_p   = PH_BIT_LA;
				end
				ACT_STOP: begin
					enter_en = 1'b1;
					enter_p  = PH_STOP_LOW;
				end
				default: ;
			endcase
		end else if (cnt_inc >= dur) begin
			enter_en = 1'b1;
			unique case (phase_q)
				PH_START_REL:   enter_p = PH_START_SETUP;
				PH_START_SETUP: enter_p = PH_START_HOLD;
				PH_START_HOLD: begin
					n_bit   = '0;
					enter_p = PH_BIT_LA;
				end
				PH_BIT_LA:      enter_p = PH_BIT_LB;
				PH_BIT_LB:      enter_p = PH_BIT_HA;
				PH_BIT_HA: begin
					n_shift = {shift_q[6:0], reading_q & item.sda_level};
					enter_p = PH_BIT_HB;
				end
				PH_BIT_HB: begin
					n_bit   = bit_q + 4'd1;
					enter_p = (n_bit >= BITS_PER_BYTE) ? PH_ACK_LA : PH_BIT_LA;
				end
				PH_ACK_LA:      enter_p = PH_ACK_LB;
				PH_ACK_LB:      enter_p = PH_ACK_HA;
				PH_ACK_HA:      enter_p = PH_ACK_HB;
				PH_ACK_HB: begin
					enter_en = 1'b0;
					n_scl    = 1'b0;
					n_sda    = 1'b0;
					if (reading_q) begin
						n_rx_hold = shift_q;
						rxv       = 1'b1;
						n_reading = 1'b0;
					end
					n_phase = PH_IDLE;
					n_tick  = '0;
				end
				PH_STOP_LOW:    enter_p = PH_STOP_SCL;
				PH_STOP_SCL:    enter_p = PH_STOP_SDA;
				default: begin
					enter_en = 1'b0;
					n_phase  = PH_IDLE;
					n_tick   = '0;
				end
			endcase
		end else begin
			n_tick = cnt_inc[COUNTER_WIDTH-1:0];
		end

		if (enter_en) begin
			n_phase = enter_p;
			n_tick  = '0;
			unique case (enter_p)
				PH_START_REL:   n_sda = 1'b1;
				PH_START_SETUP: begin
					n_scl = 1'b1;
					n_sda = 1'b1;
				end
				PH_START_HOLD:  n_sda = 1'b0;
				PH_BIT_LA: begin
					n_scl = 1'b0;
					n_sda = n_reading | n_shift[7];
				end
				PH_BIT_HA:      n_scl = 1'b1;
				PH_ACK_LA: begin
					n_scl = 1'b0;
					n_sda = n_reading ? n_nack : 1'b1;
				end
				PH_ACK_HA:      n_scl = 1'b1;
				PH_STOP_LOW: begin
					n_scl = 1'b0;
					n_sda = 1'b0;
				end
				PH_STOP_SCL:    n_scl = 1'b1;
				PH_STOP_SDA:    n_sda = 1'b1;
				default: ;
			endcase
		end

		nxt.scl_release = n_scl;
		nxt.sda_release = n_sda;
		nxt.busy_res    = (n_phase != PH_IDLE);
		nxt.rx_valid    = rxv;
		nxt.rx_byte     = n_rx_hold;
	end

	a_rx_from_read_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(step && nxt.rx_valid) |-> (phase_q == PH_ACK_HB && reading_q))
		else $error("received byte reported outside a read ack slot");

	a_hold_without_step: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> ($stable(phase_q) && $stable(tick_q) && $stable(shift_q)))
		else $error("state moved without a tick");

	a_bit_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= BITS_PER_BYTE)
		else $error("bit counter past one byte");

	a_idle_tick_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_IDLE && item.action == ACT_TICK) |=>
		(phase_q == PH_IDLE && $stable(scl_q) && $stable(sda_q)))
		else $error("idle tick changed the bus");

endmodule

// File: rtl/i2c_open_drain_master.sv
// ----------------------------------------------------------------------------
// i2c_open_drain_master
// Open-drain I2C master driven by one timer tick per command transfer.
//
//   channel  dir  payload
//   cmd      in   action, device_addr, read_flag, data_byte, send_nack, sda_level
//   res      out  scl_release, sda_release, busy_res, rx_valid, rx_byte
//   cfg      in   index, data (quarter_ticks, start_setup_ticks)
//
// one transfer per cycle sustained unless the result stalls; a command passes
// the input register, then the result register after the bus state update
// the next-state logic of the bus state machine sets the cycle
// reset puts both lines released, idle, registers at 100 and 400 ticks
// a stalled result holds; the input register keeps taking transfers
// while the result register is empty or being taken
// ----------------------------------------------------------------------------
module i2c_open_drain_master
	import i2cm_pkg::*;
#(
	parameter int COUNTER_WIDTH = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	i2cm_cmd_if.sink   cmd,
	i2cm_res_if.source res,
	i2cm_cfg_if.sink   cfg
);

	logic                  valid_s1;
	cmd_t                  cmd_s1;
	logic                  out_valid_q;
	res_t                  res_q;
	res_t                  nxt;
	logic                  step;
	logic [CFG_DATA_W-1:0] quarter_q;
	logic [CFG_DATA_W-1:0] setup_q;

	assign step      = valid_s1 && (!out_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || step;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= '{action:      cmd.action,
			            device_addr: cmd.device_addr,
			            read_flag:   cmd.read_flag,
			            data_byte:   cmd.data_byte,
			            send_nack:   cmd.send_nack,
			            sda_level:   cmd.sda_level};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quarter_q <= QUARTER_RESET;
			setup_q   <= SETUP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_QUARTER: quarter_q <= cfg.data;
				REG_SETUP:   setup_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	i2cm_core #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (step),
		.item              (cmd_s1),
		.quarter_ticks     (quarter_q),
		.start_setup_ticks (setup_q),
		.nxt               (nxt)
	);

	assign res.valid       = out_valid_q;
	assign res.scl_release = res_q.scl_release;
	assign res.sda_release = res_q.sda_release;
	assign res.busy_res    = res_q.busy_res;
	assign res.rx_valid    = res_q.rx_valid;
	assign res.rx_byte     = res_q.rx_byte;

endmodule
